FILE: rtl/unsigned_decimal_field_formatter_defines.svh
// assertion macros for the unsigned decimal field formatter
// no dependencies; included by files that carry concurrent checks
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define UFMT_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled during reset
`define UFMT_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UFMT_CHECK(label, clk, rst, ante, cons, msg)
`define UFMT_CHECK_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/ufmt_pkg.sv
// shared types and constants of the unsigned decimal field formatter
// no dependencies; imported by every module of the block
`default_nettype none

package ufmt_pkg;

   localparam int MAX_FIELD_DEFAULT = 64;
   localparam int NUM_DIGITS        = 20;

   // operand size codes
   localparam logic [1:0] LEN_8  = 2'd0;
   localparam logic [1:0] LEN_16 = 2'd1;
   localparam logic [1:0] LEN_32 = 2'd2;
   localparam logic [1:0] LEN_64 = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SETUP,
      B_EMIT
   } back_state_type;

   // classified conversion handed from front to back
   typedef struct packed {
      logic [NUM_DIGITS-1:0][3:0] digits;
      logic [4:0]                 ndig;
      logic [6:0]                 width;
      logic                       prec_on;
      logic [6:0]                 prec;
      logic                       zpad;
      logic                       left;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/ufmt_front.sv
// front end: accepts requests, truncates and converts the value to bcd
// one bit per cycle (shift and add-3), then pushes a command; uses ufmt_pkg
`default_nettype none

module ufmt_front import ufmt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_length_code,
   input  wire logic [6:0]  req_field_width,
   input  wire logic        req_precision_given,
   input  wire logic [6:0]  req_precision,
   input  wire logic        req_zero_pad,
   input  wire logic        req_left_justify,
   output logic             q_push,
   output cmd_type          q_data,
   input  wire logic        q_full
);

   front_state_type state_ff, state_in;
   logic [63:0] shift_ff, shift_in;
   logic [NUM_DIGITS*4-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [6:0] cnt_ff, cnt_in;
   logic [6:0] width_ff, prec_ff;
   logic       prec_on_ff, zpad_ff, left_ff;
   logic [4:0] ndig;
   logic       accept;

   assign accept = req_push && !req_full;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   // digit count: highest nonzero digit, a lone zero, or none at all
   always_comb begin
      ndig = 5'd0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            ndig = 5'(i + 1);
         end
      end
      if (ndig == 5'd0) begin
         ndig = (prec_on_ff && prec_ff == 7'd0) ? 5'd0 : 5'd1;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      if (accept) begin
         width_ff   <= req_field_width;
         prec_on_ff <= req_precision_given;
         prec_ff    <= req_precision;
         zpad_ff    <= req_zero_pad;
         left_ff    <= req_left_justify;
      end
   end

   // next state, conversion steps and queue push
   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      req_full = 1'b1;
      q_push   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               bcd_in   = '0;
               state_in = F_CONV;
               case (req_length_code)
                  LEN_8: begin
                     shift_in = {req_value[7:0], 56'd0};
                     cnt_in   = 7'd8;
                  end
                  LEN_16: begin
                     shift_in = {req_value[15:0], 48'd0};
                     cnt_in   = 7'd16;
                  end
                  LEN_32: begin
                     shift_in = {req_value[31:0], 32'd0};
                     cnt_in   = 7'd32;
                  end
                  LEN_64: begin
                     shift_in = req_value;
                     cnt_in   = 7'd64;
                  end
                  default: begin
                     shift_in = req_value;
                     cnt_in   = 7'd64;
                  end
               endcase
            end
         end
         F_CONV: begin
            bcd_in   = {bcd_adj[NUM_DIGITS*4-2:0], shift_ff[63]};
            shift_in = {shift_ff[62:0], 1'b0};
            cnt_in   = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign q_data.digits  = bcd_ff;
   assign q_data.ndig    = ndig;
   assign q_data.width   = width_ff;
   assign q_data.prec_on = prec_on_ff;
   assign q_data.prec    = prec_ff;
   assign q_data.zpad    = zpad_ff;
   assign q_data.left    = left_ff;

endmodule

`default_nettype wire

FILE: rtl/ufmt_queue.sv
// two-entry command queue between front and back
// uses cmd_type from ufmt_pkg
`default_nettype none

module ufmt_queue import ufmt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ufmt_back.sv
// back end: lays out padding, leading zeros and digits and emits one character
// per cycle into the output register while it is free or popped; uses ufmt_pkg
`default_nettype none

module ufmt_back import ufmt_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_data,
   output logic         q_pop,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_character,
   output logic         rsp_last,
   output logic [6:0]   rsp_total_count
);

   back_state_type state_ff, state_in;
   cmd_type    cmd_ff;
   logic [6:0] body_ff, body_in, total_ff, total_in, rem_ff, rem_in, off_ff, off_in;
   logic       pad_zero_ff, pad_zero_in;
   logic       out_valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic [6:0] count_ff;
   logic [6:0] width_sat, prec_eff, body, total, r2;
   logic [7:0] char_sel;
   logic       emit_go;

   function automatic logic [6:0] sat_field(input logic [6:0] v);
      sat_field = ({1'b0, v} > 8'(MAX_FIELD)) ? 7'(MAX_FIELD) : v;
   endfunction

   // field layout from the queued command
   always_comb begin
      width_sat = sat_field(cmd_ff.width);
      prec_eff  = cmd_ff.prec_on ? sat_field(cmd_ff.prec) : 7'd0;
      body      = ({2'd0, cmd_ff.ndig} > prec_eff) ? {2'd0, cmd_ff.ndig} : prec_eff;
      total     = (width_sat > body) ? width_sat : body;
   end

   // character at the current position, counted down from the field end
   always_comb begin
      r2 = rem_ff - off_ff;
      if (rem_ff < off_ff) begin
         char_sel = CHAR_SPACE;
      end else if (r2 < {2'd0, cmd_ff.ndig}) begin
         char_sel = CHAR_ZERO + {4'd0, cmd_ff.digits[r2[4:0]]};
      end else if (r2 < body_ff) begin
         char_sel = CHAR_ZERO;
      end else begin
         char_sel = pad_zero_ff ? CHAR_ZERO : CHAR_SPACE;
      end
   end

   assign emit_go = (state_ff == B_EMIT) && (!out_valid_ff || rsp_pop);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // layout registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      body_ff     <= body_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      off_ff      <= off_in;
      pad_zero_ff <= pad_zero_in;
   end

   // next state and layout
   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      body_in     = body_ff;
      total_in    = total_ff;
      rem_in      = rem_ff;
      off_in      = off_ff;
      pad_zero_in = pad_zero_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = B_SETUP;
            end
         end
         B_SETUP: begin
            body_in     = body;
            total_in    = total;
            rem_in      = total - 7'd1;
            off_in      = cmd_ff.left ? (total - body) : 7'd0;
            pad_zero_in = cmd_ff.zpad && !cmd_ff.prec_on && !cmd_ff.left;
            state_in    = (total == 7'd0) ? B_IDLE : B_EMIT;
         end
         B_EMIT: begin
            if (emit_go) begin
               rem_in = rem_ff - 7'd1;
               if (rem_ff == 7'd0) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         char_ff  <= char_sel;
         last_ff  <= (rem_ff == 7'd0);
         count_ff <= (rem_ff == 7'd0) ? total_ff : 7'd0;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_character   = char_ff;
   assign rsp_last        = last_ff;
   assign rsp_total_count = count_ff;

endmodule

`default_nettype wire

FILE: rtl/unsigned_decimal_field_formatter.sv
// the front converts the 8, 16, 32 or 64 bits chosen by the length code and pushes
// the command into the queue; the back pops it, lays out the field in its setup state
// and then emits one character per cycle while pop keeps up
// the front takes no new request until it has pushed the previous command; while the
// queue has room it can convert the next value while the back is still emitting
// reset: synchronous, active high; clears control state, no memory to sweep
`default_nettype none

`include "unsigned_decimal_field_formatter_defines.svh"

module unsigned_decimal_field_formatter import ufmt_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_length_code,
   input  wire logic [6:0]  req_field_width,
   input  wire logic        req_precision_given,
   input  wire logic [6:0]  req_precision,
   input  wire logic        req_zero_pad,
   input  wire logic        req_left_justify,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_character,
   output logic             rsp_last,
   output logic [6:0]       rsp_total_count
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wr_data, q_rd_data;

   // request intake and binary to bcd conversion
   ufmt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_value           (req_value),
      .req_length_code     (req_length_code),
      .req_field_width     (req_field_width),
      .req_precision_given (req_precision_given),
      .req_precision       (req_precision),
      .req_zero_pad        (req_zero_pad),
      .req_left_justify    (req_left_justify),
      .q_push              (q_push),
      .q_data              (q_wr_data),
      .q_full              (q_full)
   );

   // command queue
   ufmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   // character emitter
   ufmt_back #(
      .MAX_FIELD (MAX_FIELD)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_rd_data),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .rsp_total_count (rsp_total_count)
   );

   // checks on the result stream and the intake
   `UFMT_CHECK(a_last_count, clock, reset, !rsp_empty && rsp_last,
      rsp_total_count != 7'd0, "last character without a count")
   `UFMT_CHECK(a_mid_count, clock, reset, !rsp_empty && !rsp_last,
      rsp_total_count == 7'd0, "count on a character that is not last")
   `UFMT_CHECK(a_count_limit, clock, reset, !rsp_empty && rsp_last,
      8'(rsp_total_count) <= 8'(MAX_FIELD), "count beyond field limit")
   `UFMT_CHECK_NEXT(a_busy_after_accept, clock, reset, req_push && !req_full,
      req_full, "front not busy after accepting")

endmodule

`default_nettype wire
